// ===== design/pli_pkg.sv =====
`timescale 1ns / 1ps
// pli_pkg: shared types and constants of the piecewise linear interpolator
// used by pli_cell, pli_divider and piecewise_linear_interpolator; no dependencies

package pli_pkg;

   // capacity of the sample store, one cell per point
   localparam int MAX_POINTS = 16;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // widths of the serial multiply and divide datapath
   localparam int MAG_W  = 33;   // magnitude of a 33-bit difference
   localparam int QUO_W  = 65;   // product plus rounding bias
   localparam int REM_W  = 32;   // divisor and remainder
   localparam int STEP_W = 7;

   localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(MAG_W);
   localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(QUO_W);

   // saturation bounds of a q16.16 value
   localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] interpolated_value;
      logic               averaged;
      logic               saturated;
      logic               points_dropped;
   } rsp_type;

   // one sample point as held by a cell
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } sample_type;

   // per-cycle command broadcast to the row of cells
   typedef struct packed {
      logic load;    // insert the new point in x order
      logic shift;   // move every point one cell toward the head
   } cell_ctrl_type;

endpackage

// ===== design/pli_cell.sv =====
`timescale 1ns / 1ps
// pli_cell: one cell of the sorted sample row, holds a single point
// depends on pli_pkg (sample_type, cell_ctrl_type)

module pli_cell (
   input  logic                   clock,
   input  pli_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  pli_pkg::sample_type    new_point,
   input  pli_pkg::sample_type    left_point,
   input  logic                   left_after,
   input  pli_pkg::sample_type    right_point,
   output pli_pkg::sample_type    point,
   output logic                   after
);
   import pli_pkg::*;

   sample_type point_ff;
   sample_type point_in;

   // the new point goes behind every held point with x not above it
   assign after = !occupied || (point_ff.x > new_point.x);
   assign point = point_ff;

   // insert: take the neighbor's point if it also moves, else the new one; shift: take the right neighbor's point
   always_comb begin
      point_in = point_ff;
      if (ctrl.load && after) begin
         point_in = left_after ? left_point : new_point;
      end else if (ctrl.shift) begin
         point_in = right_point;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
   end

endmodule

// ===== design/pli_divider.sv =====
`timescale 1ns / 1ps
// pli_divider: bit-serial multiply, rounding bias and restoring divide
// computes (a * b + divisor / 2) / divisor; depends on pli_pkg

module pli_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pli_pkg::MAG_W-1:0]   mult_a,
   input  logic [pli_pkg::MAG_W-1:0]   mult_b,
   input  logic [pli_pkg::REM_W-1:0]   divisor,
   output logic                        done,
   output logic [pli_pkg::QUO_W-1:0]   quotient
);
   import pli_pkg::*;

   typedef enum logic [1:0] {DV_IDLE, DV_MUL, DV_BIAS, DV_DIV} dv_state_type;

   dv_state_type      state_ff;
   logic [STEP_W-1:0] step_ff;
   logic [MAG_W-1:0]  a_ff;
   logic [MAG_W-1:0]  b_ff;
   logic [QUO_W-1:0]  acc_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  dvs_ff;
   logic              done_ff;

   logic [QUO_W-1:0]  mul_in;
   logic [REM_W+1:0]  trial;

   // shift-add step over the multiplier bits, msb first
   assign mul_in = {acc_ff[QUO_W-2:0], 1'b0}
                 + (b_ff[MAG_W-1] ? QUO_W'(a_ff) : QUO_W'(0));

   // restoring divide step: remainder with the next numerator bit
   assign trial = {1'b0, rem_ff, acc_ff[QUO_W-1]} - {2'b00, dvs_ff};

   assign done     = done_ff;
   assign quotient = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            DV_IDLE: begin
               if (start) begin
                  a_ff     <= mult_a;
                  b_ff     <= mult_b;
                  dvs_ff   <= divisor;
                  acc_ff   <= '0;
                  step_ff  <= MUL_STEPS;
                  state_ff <= DV_MUL;
               end
            end
            DV_MUL: begin
               acc_ff  <= mul_in;
               b_ff    <= {b_ff[MAG_W-2:0], 1'b0};
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == STEP_W'(1)) begin
                  state_ff <= DV_BIAS;
               end
            end
            // round to nearest by adding half the divisor
            DV_BIAS: begin
               acc_ff   <= acc_ff + QUO_W'(dvs_ff >> 1);
               rem_ff   <= '0;
               step_ff  <= DIV_STEPS;
               state_ff <= DV_DIV;
            end
            DV_DIV: begin
               if (!trial[REM_W+1]) begin
                  rem_ff <= trial[REM_W-1:0];
                  acc_ff <= {acc_ff[QUO_W-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[REM_W-2:0], acc_ff[QUO_W-1]};
                  acc_ff <= {acc_ff[QUO_W-2:0], 1'b0};
               end
               step_ff <= step_ff - STEP_W'(1);
               if (step_ff == STEP_W'(1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= DV_IDLE;
               end
            end
            default: begin
               state_ff <= DV_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/piecewise_linear_interpolator.sv =====
`timescale 1ns / 1ps
// piecewise_linear_interpolator: top level, row of sorting cells and control
// depends on pli_pkg, pli_cell and pli_divider
//
// Usage:
// - csr channel writes target_x (signed q16.16); write it only while idle.
// - req channel carries one sample point per request, in any order. Points
//   are inserted into a row of MAX_POINTS cells kept sorted by x (stable),
//   one request per cycle while loading. Points beyond MAX_POINTS are dropped and flagged.
// - the request with is_last closes the set. The bracket search then moves
//   the row one cell per cycle (up to MAX_POINTS-2 steps), and a bit-serial
//   unit forms the product and then the rounded quotient.
// - the response to a single point or to coincident bracket x does not pass
//   through the serial multiply/divide unit.
// - throughput: one point per cycle while loading; req_ready is low from the
//   closing request until its response is written to the output register.
// - rsp channel holds a registered response; while the receiver stalls the
//   next set still loads, but requests after its closing request wait.
// - reset clears the point count, drop flag, target_x and the response valid.

module piecewise_linear_interpolator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pli_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pli_pkg::rsp_type     rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic signed [31:0]   csr_target_x
);
   import pli_pkg::*;

   typedef enum logic [2:0] {ST_LOAD, ST_SEARCH, ST_PREP, ST_CALC, ST_OUT} state_type;

   localparam int HiCell = (MAX_POINTS > 1) ? 1 : 0;

   state_type          state_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   k_ff;
   logic               drop_ff;
   logic signed [31:0] target_ff;
   logic signed [31:0] y0_ff;
   logic               neg_ff;
   rsp_type            result_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   sample_type         cell_point [MAX_POINTS];
   logic               cell_after [MAX_POINTS];
   cell_ctrl_type      ctrl;
   sample_type         new_point;

   logic               req_fire;
   logic               room;
   logic               advance;
   logic               out_free;

   logic signed [32:0] diff_y;
   logic signed [32:0] diff_t;
   logic signed [32:0] diff_x;
   logic signed [32:0] pair_sum;
   logic [MAG_W-1:0]   mag_y;
   logic [MAG_W-1:0]   mag_t;
   logic               div_start;
   logic               div_done;
   logic [QUO_W-1:0]   div_quotient;

   logic               q_big;
   logic signed [34:0] q_signed;
   logic signed [34:0] sum_full;
   rsp_type            interp_result;

   // handshakes
   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign room        = (count_ff < CNT_W'(MAX_POINTS));
   assign new_point.x = req_data.point_x;
   assign new_point.y = req_data.point_y;

   // bracket moves up while the upper x lies below the target
   assign advance = (k_ff < count_ff - CNT_W'(1))
                 && (cell_point[HiCell].x < target_ff);

   assign ctrl.load  = req_fire && room;
   assign ctrl.shift = (state_ff == ST_SEARCH) && (count_ff > CNT_W'(1)) && advance;

   // row of sorting cells
   for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
      sample_type left_point;
      logic       left_after;
      sample_type right_point;
      logic       occupied;

      if (g == 0) begin : g_head
         assign left_point = new_point;
         assign left_after = 1'b0;
      end else begin : g_body
         assign left_point = cell_point[g-1];
         assign left_after = cell_after[g-1];
      end
      if (g == MAX_POINTS - 1) begin : g_tail
         assign right_point = cell_point[g];
      end else begin : g_inner
         assign right_point = cell_point[g+1];
      end
      assign occupied = (CNT_W'(g) < count_ff);

      pli_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied),
         .new_point   (new_point),
         .left_point  (left_point),
         .left_after  (left_after),
         .right_point (right_point),
         .point       (cell_point[g]),
         .after       (cell_after[g])
      );
   end

   // bracket differences, lower point in the head cell
   always_comb begin
      diff_y   = 33'(cell_point[HiCell].y) - 33'(cell_point[0].y);
      diff_t   = 33'(target_ff) - 33'(cell_point[0].x);
      diff_x   = 33'(cell_point[HiCell].x) - 33'(cell_point[0].x);
      pair_sum = 33'(cell_point[HiCell].y) + 33'(cell_point[0].y);
      mag_y    = diff_y[32] ? MAG_W'(-diff_y) : MAG_W'(diff_y);
      mag_t    = diff_t[32] ? MAG_W'(-diff_t) : MAG_W'(diff_t);
   end

   assign div_start = (state_ff == ST_PREP) && (diff_x != 33'sd0);

   pli_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .mult_a   (mag_y),
      .mult_b   (mag_t),
      .divisor  (diff_x[REM_W-1:0]),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // apply the signed quotient to y0 and clamp
   always_comb begin
      q_big    = (div_quotient[QUO_W-1:34] != '0)
              || (div_quotient[33] && (div_quotient[32:0] != '0));
      q_signed = $signed({1'b0, div_quotient[33:0]});
      sum_full = 35'(y0_ff) + (neg_ff ? -q_signed : q_signed);
      interp_result.averaged       = 1'b0;
      interp_result.points_dropped = drop_ff;
      interp_result.saturated      = 1'b1;
      if (q_big) begin
         interp_result.interpolated_value = neg_ff ? VALUE_MIN : VALUE_MAX;
      end else if (sum_full > 35'(VALUE_MAX)) begin
         interp_result.interpolated_value = VALUE_MAX;
      end else if (sum_full < 35'(VALUE_MIN)) begin
         interp_result.interpolated_value = VALUE_MIN;
      end else begin
         interp_result.saturated          = 1'b0;
         interp_result.interpolated_value = sum_full[31:0];
      end
   end

   // control state, configuration and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         k_ff         <= '0;
         drop_ff      <= 1'b0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            target_ff <= csr_target_x;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  if (room) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  if (req_data.is_last) begin
                     k_ff     <= CNT_W'(1);
                     state_ff <= ST_SEARCH;
                  end
               end
            end
            ST_SEARCH: begin
               if (count_ff <= CNT_W'(1)) begin
                  // single point returns its own y
                  result_ff.interpolated_value <= cell_point[0].y;
                  result_ff.averaged           <= 1'b0;
                  result_ff.saturated          <= 1'b0;
                  result_ff.points_dropped     <= drop_ff;
                  state_ff                     <= ST_OUT;
               end else if (advance) begin
                  k_ff <= k_ff + CNT_W'(1);
               end else begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               y0_ff  <= cell_point[0].y;
               neg_ff <= diff_y[32] ^ diff_t[32];
               if (diff_x == 33'sd0) begin
                  // coincident x: floor of the mean of the two y values
                  result_ff.interpolated_value <= pair_sum[32:1];
                  result_ff.averaged           <= 1'b1;
                  result_ff.saturated          <= 1'b0;
                  result_ff.points_dropped     <= drop_ff;
                  state_ff                     <= ST_OUT;
               end else begin
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               if (div_done) begin
                  result_ff <= interp_result;
                  state_ff  <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= result_ff;
                  count_ff     <= '0;
                  drop_ff      <= 1'b0;
                  state_ff     <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench of piecewise_linear_interpolator, point sets against a predictor
// depends on pli_pkg and piecewise_linear_interpolator

// scoreboard: holds the open point set, the target and the expected responses
class interp_scoreboard;
   logic signed [31:0]   target_x;
   logic signed [31:0]   set_x[$];
   logic signed [31:0]   set_y[$];
   bit                   set_dropped;
   pli_pkg::rsp_type     expected_values[$];
   int                   errors;

   function new();
      target_x = '0;
      set_dropped = 1'b0;
      errors = 0;
   endfunction

   function void set_target(input logic signed [31:0] t);
      target_x = t;
   endfunction

   function int pending();
      return expected_values.size();
   endfunction

   // value at target_x for the points held in the set
   function pli_pkg::rsp_type interpolate();
      int                n, i, j, lo, hi, tmp;
      int                order[pli_pkg::MAX_POINTS];
      longint            x0, x1, y0, y1, dy, dt, dx, s, r;
      bit [64:0]         mag_dy, mag_dt, mag_dx, prod, q;
      bit                neg;
      pli_pkg::rsp_type  res;
      n = set_x.size();
      res = '0;
      res.points_dropped = set_dropped;
      if (n == 1) begin
         res.interpolated_value = set_y[0];
         return res;
      end
      // stable insertion sort of point indexes by x
      for (i = 0; i < n; i++) order[i] = i;
      for (i = 1; i < n; i++) begin
         j = i;
         while (j > 0 && set_x[order[j]] < set_x[order[j-1]]) begin
            tmp = order[j];
            order[j] = order[j-1];
            order[j-1] = tmp;
            j--;
         end
      end
      // bracket search, move up while the upper x lies below the target
      lo = order[0];
      hi = order[1];
      for (i = 2; i < n && set_x[hi] < target_x; i++) begin
         lo = hi;
         hi = order[i];
      end
      x0 = set_x[lo];
      x1 = set_x[hi];
      y0 = set_y[lo];
      y1 = set_y[hi];
      // coincident bracket x, floor of the mean
      if (x0 == x1) begin
         s = y0 + y1;
         res.interpolated_value = 32'(s >>> 1);
         res.averaged = 1'b1;
         return res;
      end
      // exact quotient rounded half away from zero, then clamp
      dy = y1 - y0;
      dt = longint'(target_x) - x0;
      dx = x1 - x0;
      neg = (dy < 0) != (dt < 0);
      mag_dy = (dy < 0) ? -dy : dy;
      mag_dt = (dt < 0) ? -dt : dt;
      mag_dx = dx;
      prod = mag_dy * mag_dt;
      q = (prod + (mag_dx >> 1)) / mag_dx;
      if (q > 65'h2_0000_0000) begin
         res.saturated = 1'b1;
         res.interpolated_value = neg ? pli_pkg::VALUE_MIN : pli_pkg::VALUE_MAX;
         return res;
      end
      r = neg ? y0 - longint'(q) : y0 + longint'(q);
      if (r > longint'(pli_pkg::VALUE_MAX)) begin
         res.saturated = 1'b1;
         r = pli_pkg::VALUE_MAX;
      end else if (r < longint'(pli_pkg::VALUE_MIN)) begin
         res.saturated = 1'b1;
         r = pli_pkg::VALUE_MIN;
      end
      res.interpolated_value = 32'(r);
      return res;
   endfunction

   // accepted request: store the point, close the set on is_last
   function void note_point(input pli_pkg::req_type p);
      if (set_x.size() < pli_pkg::MAX_POINTS) begin
         set_x.push_back(p.point_x);
         set_y.push_back(p.point_y);
      end else begin
         set_dropped = 1'b1;
      end
      if (p.is_last) begin
         expected_values.push_back(interpolate());
         set_x.delete();
         set_y.delete();
         set_dropped = 1'b0;
      end
   endfunction

   function void compare_field(input string name, input longint exp_v, input longint got_v);
      if (exp_v != got_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
         errors++;
      end
   endfunction

   // accepted response against the oldest expectation
   function void check_result(input pli_pkg::rsp_type got);
      pli_pkg::rsp_type exp_r;
      if (expected_values.size() == 0) begin
         $error("response with none expected, interpolated_value %0d",
                got.interpolated_value);
         errors++;
         return;
      end
      exp_r = expected_values.pop_front();
      compare_field("interpolated_value", exp_r.interpolated_value, got.interpolated_value);
      compare_field("averaged", exp_r.averaged, got.averaged);
      compare_field("saturated", exp_r.saturated, got.saturated);
      compare_field("points_dropped", exp_r.points_dropped, got.points_dropped);
   endfunction
endclass

module tb;
   import pli_pkg::*;

   localparam int PHASES           = 8;
   localparam int POINTS_PER_PHASE = 194;
   localparam int SETTLE_CYCLES    = MAX_POINTS + 120;
   localparam int HOLD_CYCLES      = 600;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_type            req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_type            rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic signed [31:0] csr_target_x;

   interp_scoreboard   sb;
   int                 burst_left = 0;
   int                 points_sent = 0;
   bit                 pressure_due = 1'b0;

   piecewise_linear_interpolator uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_target_x (csr_target_x)
   );

   // clock
   always #5 clock = ~clock;

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_result(rsp_data);
   end

   // one point request, in bursts with random gaps
   task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic last);
      req_type p;
      int      gap;
      p.point_x = x;
      p.point_y = y;
      p.is_last = last;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      sb.note_point(p);
      points_sent++;
   endtask

   // wait until every response is back and the block has settled
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_target(input logic signed [31:0] t);
      csr_valid    <= 1'b1;
      csr_target_x <= t;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_target(t);
   endtask

   // random coordinate: full range, near a center, few distinct values, extremes
   function automatic logic signed [31:0] pick_value(input int mode,
                                                     input logic signed [31:0] center);
      longint v;
      case (mode)
         0: v = longint'($signed($urandom()));
         1: v = longint'(center) + longint'($urandom_range(0, 1 << 21)) - (1 << 20);
         2: v = longint'(center) + (longint'($urandom_range(0, 6)) - 3) * 65536;
         default: begin
            case ($urandom_range(0, 5))
               0: v = VALUE_MIN;
               1: v = VALUE_MAX;
               2: v = 0;
               3: v = -1;
               4: v = 1;
               default: v = center;
            endcase
         end
      endcase
      if (v > longint'(VALUE_MAX)) v = VALUE_MAX;
      if (v < longint'(VALUE_MIN)) v = VALUE_MIN;
      return 32'(v);
   endfunction

   // one closed point set of random size and content
   task automatic send_random_set();
      int n, k, i, mode_x, mode_y;
      k = $urandom_range(0, 19);
      if (k == 0)      n = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4);
      else if (k < 4)  n = 1;
      else if (k < 8)  n = 2;
      else             n = $urandom_range(3, MAX_POINTS);
      mode_x = $urandom_range(0, 3);
      mode_y = $urandom_range(0, 3);
      for (i = 0; i < n; i++)
         send_point(pick_value(mode_x, sb.target_x), pick_value(mode_y, 32'sd0), i == n - 1);
   endtask

   // receiver: stall pattern changing every stretch, one long hold-off on request
   initial begin
      int   mode, span, hold_left, step;
      logic [15:0] pattern;
      rsp_ready <= 1'b0;
      hold_left = 0;
      forever begin
         mode    = $urandom_range(0, 3);
         span    = $urandom_range(8, 64);
         pattern = 16'($urandom());
         for (step = 0; step < span; step++) begin
            @(posedge clock);
            if (pressure_due) begin
               pressure_due = 1'b0;
               hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
               rsp_ready <= 1'b0;
               hold_left--;
            end else begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= 1'($urandom_range(0, 1));
                  2: rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= pattern[step % 16];
               endcase
            end
         end
      end
   end

   // run limit
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // main sequence
   initial begin
      int                 phase, i, start;
      logic signed [31:0] tgt;
      sb = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_valid    <= 1'b0;
      csr_target_x <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sets at target zero
      write_target(32'sd0);
      // single point
      send_point(VALUE_MAX, VALUE_MIN, 1'b1);
      // coincident x, negative odd sum
      send_point(32'sd5, 32'sd3, 1'b0);
      send_point(32'sd5, -32'sd4, 1'b1);
      // extreme x and y, interpolation across the whole range
      send_point(VALUE_MIN, VALUE_MAX, 1'b0);
      send_point(VALUE_MAX, VALUE_MIN, 1'b1);
      // extrapolation that saturates high
      send_point(-32'sd2, 32'sd0, 1'b0);
      send_point(-32'sd1, VALUE_MAX, 1'b1);
      // store full, the closing point is dropped
      for (i = 0; i <= MAX_POINTS; i++)
         send_point(pick_value(1, 32'sd0), pick_value(0, 32'sd0), i == MAX_POINTS);
      drain();

      // random phases, each with its own target
      for (phase = 1; phase <= PHASES; phase++) begin
         case (phase)
            1: tgt = VALUE_MIN;
            2: tgt = VALUE_MAX;
            3: tgt = 32'sd0;
            default: tgt = ($urandom_range(0, 1) == 1) ? $signed($urandom())
                                                       : pick_value(1, 32'sd0);
         endcase
         write_target(tgt);
         if (phase == 4) pressure_due = 1'b1;
         start = points_sent;
         while (points_sent - start < POINTS_PER_PHASE) send_random_set();
         drain();
      end

      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
design/pli_pkg.sv
design/pli_cell.sv
design/pli_divider.sv
design/piecewise_linear_interpolator.sv
tb/tb.sv
